FILE: design/vdm_pkg.sv
// Shared types and constants for the vector distance block.
// Used by every module of vector_distance_metrics; depends on nothing.
package vdm_pkg;

  localparam int unsigned MaxDimDef = 1024;
  localparam int unsigned QueueDepth = 4;

  localparam logic signed [63:0] AccMax = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] AccMin = 64'shC000_0000_0000_0000;
  localparam logic signed [63:0] OneQ24 = 64'sd16777216;

  typedef enum logic [1:0] {
    MET_L1   = 2'd0,
    MET_IP   = 2'd1,
    MET_L2SQ = 2'd2,
    MET_COS  = 2'd3
  } metric_e;

  localparam metric_e MetricReset = MET_L2SQ;

  typedef enum logic [2:0] {
    BK_ACC,
    BK_FIN,
    BK_NORM,
    BK_MUL,
    BK_SQRT,
    BK_DIV,
    BK_COS,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic signed [15:0] a_elem;
    logic signed [15:0] b_elem;
    logic               last;
  } vdm_in_t;

  typedef struct packed {
    logic signed [62:0] distance;
    logic               saturated;
  } vdm_out_t;

  typedef struct packed {
    logic signed [15:0] a_elem;
    logic signed [15:0] b_elem;
    logic               last;
    logic               use_elem;
    metric_e            metric;
  } vdm_item_t;

endpackage

FILE: design/vdm_front.sv
// Front end: metric register, element counting and tagging of each transaction.
// Depends on vdm_pkg; feeds vdm_queue.
module vdm_front #(
  parameter int unsigned MAX_DIM = vdm_pkg::MaxDimDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vdm_pkg::vdm_in_t    in_data_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output vdm_pkg::vdm_item_t  q_item_o
);

  localparam int unsigned CntW = $clog2(MAX_DIM + 1);

  vdm_pkg::metric_e metric_q, metric_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             use_elem;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign q_push_o    = in_valid_i && !q_full_i;
  assign use_elem    = count_q < CntW'(MAX_DIM);

  always_comb begin
    q_item_o.a_elem   = in_data_i.a_elem;
    q_item_o.b_elem   = in_data_i.b_elem;
    q_item_o.last     = in_data_i.last;
    q_item_o.use_elem = use_elem;
    q_item_o.metric   = metric_q;
    metric_d = metric_q;
    if (cfg_valid_i) begin
      metric_d = vdm_pkg::metric_e'(cfg_data_i);
    end
    count_d = count_q;
    if (q_push_o) begin
      if (in_data_i.last) begin
        count_d = '0;
      end else if (use_elem) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= vdm_pkg::MetricReset;
      count_q  <= '0;
    end else begin
      metric_q <= metric_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: design/vdm_queue.sv
// Short queue between front and back ends of the distance block.
// Depends on vdm_pkg for the item type.
module vdm_queue #(
  parameter int unsigned DEPTH = vdm_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vdm_pkg::vdm_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output vdm_pkg::vdm_item_t item_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  vdm_pkg::vdm_item_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

FILE: design/vdm_back.sv
// Back end: products, saturating sums, final metric; cosine uses an iterative root and divide.
// Depends on vdm_pkg; drains vdm_queue and owns the output register.
module vdm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  vdm_pkg::vdm_item_t item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vdm_pkg::vdm_out_t  out_data_o
);

  vdm_pkg::back_state_e state_q, state_d;
  logic s1_valid_q, s1_valid_d, out_valid_q, out_valid_d;

  logic                 s1_last_q, s1_use_q;
  vdm_pkg::metric_e     s1_metric_q, fin_metric_q, fin_metric_d;
  logic signed [35:0]   s1_inc_q;
  logic [30:0]          s1_aa_q, s1_bb_q;
  logic signed [62:0]   acc_main_q, acc_main_d, res_q, res_d;
  logic [61:0]          acc_aa_q, acc_aa_d, acc_bb_q, acc_bb_d, aan_q, aan_d, bbn_q, bbn_d;
  logic                 sat_q, sat_d, neg_q, neg_d;
  logic [6:0]           sh_q, sh_d;
  logic [63:0]          v_q, v_d, root_q, root_d;
  logic [62:0]          bit_q, bit_d;
  logic [57:0]          num_q, num_d;
  logic [31:0]          rem_q, rem_d;
  logic [5:0]           step_q, step_d;
  vdm_pkg::vdm_out_t    out_q, out_d;

  logic signed [16:0]   diff;
  logic [16:0]          adiff;
  logic signed [33:0]   sq;
  logic signed [31:0]   ab, aa, bb;
  logic signed [35:0]   inc;
  logic signed [63:0]   sum_main, ip_res;
  logic [62:0]          sum_aa, sum_bb, mag;
  logic [63:0]          sq_try;
  logic [31:0]          dvs;
  logic [32:0]          rs;
  logic [57:0]          qc;
  logic [33:0]          mag_c;
  logic                 load_out;

  always_comb begin
    diff  = 17'(item_i.a_elem) - 17'(item_i.b_elem);
    adiff = diff[16] ? 17'(-diff) : 17'(diff);
    sq    = diff * diff;
    ab    = item_i.a_elem * item_i.b_elem;
    aa    = item_i.a_elem * item_i.a_elem;
    bb    = item_i.b_elem * item_i.b_elem;
    case (item_i.metric)
      vdm_pkg::MET_L1:   inc = {7'b0, adiff, 12'b0};
      vdm_pkg::MET_L2SQ: inc = 36'(sq);
      default:           inc = 36'(ab);
    endcase
  end

  assign item_pop_o = state_q == vdm_pkg::BK_ACC && item_valid_i && !(s1_valid_q && s1_last_q);
  assign s1_valid_d = item_pop_o;

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      s1_last_q   <= item_i.last;
      s1_use_q    <= item_i.use_elem;
      s1_metric_q <= item_i.metric;
      s1_inc_q    <= inc;
      s1_aa_q     <= aa[30:0];
      s1_bb_q     <= bb[30:0];
    end
  end

  assign load_out = state_q == vdm_pkg::BK_OUT && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    acc_main_d   = acc_main_q;
    acc_aa_d     = acc_aa_q;
    acc_bb_d     = acc_bb_q;
    sat_d        = sat_q;
    fin_metric_d = fin_metric_q;
    res_d        = res_q;
    neg_d        = neg_q;
    aan_d        = aan_q;
    bbn_d        = bbn_q;
    sh_d         = sh_q;
    v_d          = v_q;
    root_d       = root_q;
    bit_d        = bit_q;
    num_d        = num_q;
    rem_d        = rem_q;
    step_d       = step_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;

    sum_main = 64'(acc_main_q) + 64'(s1_inc_q);
    sum_aa   = {1'b0, acc_aa_q} + 63'(s1_aa_q);
    sum_bb   = {1'b0, acc_bb_q} + 63'(s1_bb_q);
    ip_res   = vdm_pkg::OneQ24 - 64'(acc_main_q);
    sq_try   = root_q + {1'b0, bit_q};
    dvs      = (root_q[31:0] == '0) ? 32'd1 : root_q[31:0];
    rs       = {rem_q, num_q[57]};
    mag      = acc_main_q[62] ? 63'(-64'(acc_main_q)) : 63'(acc_main_q);
    mag      = mag >> sh_q[6:1];
    mag_c    = (mag > 63'h2_0000_0000) ? 34'h2_0000_0000 : mag[33:0];
    qc       = (num_q > 58'd16777216) ? 58'd16777216 : num_q;

    unique case (state_q)
      vdm_pkg::BK_ACC: begin
        if (s1_valid_q) begin
          if (s1_use_q) begin
            if (sum_main > vdm_pkg::AccMax) begin
              acc_main_d = vdm_pkg::AccMax[62:0];
              sat_d      = 1'b1;
            end else if (sum_main < vdm_pkg::AccMin) begin
              acc_main_d = vdm_pkg::AccMin[62:0];
              sat_d      = 1'b1;
            end else begin
              acc_main_d = sum_main[62:0];
            end
            if (sum_aa[62]) begin
              acc_aa_d = '1;
              sat_d    = 1'b1;
            end else begin
              acc_aa_d = sum_aa[61:0];
            end
            if (sum_bb[62]) begin
              acc_bb_d = '1;
              sat_d    = 1'b1;
            end else begin
              acc_bb_d = sum_bb[61:0];
            end
          end
          if (s1_last_q) begin
            fin_metric_d = s1_metric_q;
            state_d      = vdm_pkg::BK_FIN;
          end
        end
      end
      vdm_pkg::BK_FIN: begin
        state_d = vdm_pkg::BK_OUT;
        res_d   = acc_main_q;
        neg_d   = acc_main_q[62];
        aan_d   = acc_aa_q;
        bbn_d   = acc_bb_q;
        sh_d    = '0;
        if (fin_metric_q == vdm_pkg::MET_IP) begin
          if (ip_res > vdm_pkg::AccMax) begin
            res_d = vdm_pkg::AccMax[62:0];
            sat_d = 1'b1;
          end else if (ip_res < vdm_pkg::AccMin) begin
            res_d = vdm_pkg::AccMin[62:0];
            sat_d = 1'b1;
          end else begin
            res_d = ip_res[62:0];
          end
        end else if (fin_metric_q == vdm_pkg::MET_COS) begin
          if (acc_aa_q == '0 && acc_bb_q == '0) begin
            res_d = '0;
          end else if (acc_aa_q == '0 || acc_bb_q == '0) begin
            res_d = vdm_pkg::OneQ24[62:0];
          end else begin
            state_d = vdm_pkg::BK_NORM;
          end
        end
      end
      vdm_pkg::BK_NORM: begin
        if (aan_q[61:32] != '0) begin
          aan_d = aan_q >> 2;
          sh_d  = sh_q + 7'd2;
        end else if (bbn_q[61:32] != '0) begin
          bbn_d = bbn_q >> 2;
          sh_d  = sh_q + 7'd2;
        end else begin
          state_d = vdm_pkg::BK_MUL;
        end
      end
      vdm_pkg::BK_MUL: begin
        v_d     = aan_q[31:0] * bbn_q[31:0];
        root_d  = '0;
        bit_d   = 63'h4000_0000_0000_0000;
        step_d  = '0;
        state_d = vdm_pkg::BK_SQRT;
      end
      vdm_pkg::BK_SQRT: begin
        if (v_q >= sq_try) begin
          v_d    = v_q - sq_try;
          root_d = (root_q >> 1) + {1'b0, bit_q};
        end else begin
          root_d = root_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q + 6'd1;
        if (step_q == 6'd31) begin
          num_d   = {mag_c, 24'b0};
          rem_d   = '0;
          step_d  = '0;
          state_d = vdm_pkg::BK_DIV;
        end
      end
      vdm_pkg::BK_DIV: begin
        if (rs >= {1'b0, dvs}) begin
          rem_d = 32'(rs - {1'b0, dvs});
          num_d = {num_q[56:0], 1'b1};
        end else begin
          rem_d = rs[31:0];
          num_d = {num_q[56:0], 1'b0};
        end
        step_d = step_q + 6'd1;
        if (step_q == 6'd57) begin
          state_d = vdm_pkg::BK_COS;
        end
      end
      vdm_pkg::BK_COS: begin
        res_d   = neg_q ? vdm_pkg::OneQ24[62:0] + 63'(qc)
                        : vdm_pkg::OneQ24[62:0] - 63'(qc);
        state_d = vdm_pkg::BK_OUT;
      end
      vdm_pkg::BK_OUT: begin
        if (load_out) begin
          out_d.distance  = res_q;
          out_d.saturated = sat_q;
          out_valid_d     = 1'b1;
          acc_main_d      = '0;
          acc_aa_d        = '0;
          acc_bb_d        = '0;
          sat_d           = 1'b0;
          state_d         = vdm_pkg::BK_ACC;
        end
      end
      default: state_d = vdm_pkg::BK_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vdm_pkg::BK_ACC;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_main_q  <= '0;
      acc_aa_q    <= '0;
      acc_bb_q    <= '0;
      sat_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      acc_main_q  <= acc_main_d;
      acc_aa_q    <= acc_aa_d;
      acc_bb_q    <= acc_bb_d;
      sat_q       <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_metric_q <= fin_metric_d;
    res_q        <= res_d;
    neg_q        <= neg_d;
    aan_q        <= aan_d;
    bbn_q        <= bbn_d;
    sh_q         <= sh_d;
    v_q          <= v_d;
    root_q       <= root_d;
    bit_q        <= bit_d;
    num_q        <= num_d;
    rem_q        <= rem_d;
    step_q       <= step_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/vector_distance_metrics.sv
// Top level of the vector distance block: front end, queue and back end.
// Depends on vdm_pkg, vdm_front, vdm_queue and vdm_back.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | vdm_in_t  (a_elem, b_elem, last)
//   out     | output    | out_valid_o/out_stall_i | vdm_out_t (distance, saturated)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | metric, 2 bits
//
// One element pair per cycle while accumulating; the queue absorbs back-end pauses.
// After a last pair, L1, inner product and squared L2 finish through BK_FIN and BK_OUT;
// cosine adds normalising shifts, one multiply, 32 root steps, 58 divide steps and one
// closing step.
// Reset clears the sums, the count, the queue and the output valid; metric = 2.
// An output stall holds the result and, once the queue fills, stalls the input.
module vector_distance_metrics #(
  parameter int unsigned MAX_DIM = vdm_pkg::MaxDimDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vdm_pkg::vdm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vdm_pkg::vdm_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_data_i
);

  logic               q_full, q_push, q_valid, q_pop;
  vdm_pkg::vdm_item_t q_in, q_out;

  vdm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_in)
  );

  vdm_queue #(.DEPTH(vdm_pkg::QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  vdm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_out),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: design/vdm_checker.sv
// Port-level checks for vector_distance_metrics, attached by bind.
// Depends on vdm_pkg for the channel types.
module vdm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input vdm_pkg::vdm_out_t out_data_o,
  input logic              cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_reset_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result valid straight after reset");

  a_reset_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !in_stall_o && cfg_ready_o)
    else $error("input or configuration blocked straight after reset");

endmodule

bind vector_distance_metrics vdm_checker u_vdm_checker (.*);
